/* hdl/ssc_pkg.sv */
// ----------------------------------------------------------------------------
// Step cadence speed package
// Shared widths, register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int THRESH_W      = 17;
  localparam int WCOUNT_W      = 8;
  localparam int TICK_W        = 16;
  localparam int INTERVAL_W    = 16;
  localparam int SPEED_W       = 14;
  localparam int DEADBAND_W    = 15;
  localparam int PERIOD_W      = 10;
  localparam int SCALE_W       = 24;
  localparam int PRODUCT_W     = TICK_W + PERIOD_W;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;

  localparam int DEF_THRESH_WINDOW = 64;
  localparam int DEF_RING_DEPTH    = 8;

  localparam logic [SPEED_W-1:0] SPEED_MAX_Q8 = 14'd12800;

  localparam logic [2:0] REG_DEADBAND   = 3'd0;
  localparam logic [2:0] REG_PERIOD     = 3'd1;
  localparam logic [2:0] REG_MIN_IVAL   = 3'd2;
  localparam logic [2:0] REG_MAX_IVAL   = 3'd3;
  localparam logic [2:0] REG_SCALE      = 3'd4;

  localparam logic [DEADBAND_W-1:0] RST_DEADBAND = '0;
  localparam logic [PERIOD_W-1:0]   RST_PERIOD   = 10'd5;
  localparam logic [15:0]           RST_MIN_IVAL = 16'd200;
  localparam logic [15:0]           RST_MAX_IVAL = 16'd2000;
  localparam logic [SCALE_W-1:0]    RST_SCALE    = 24'd2322432;

  typedef struct packed {
    logic [DEADBAND_W-1:0] deadband;
    logic [PERIOD_W-1:0]   sample_period_ms;
    logic [15:0]           min_interval_ms;
    logic [15:0]           max_interval_ms;
    logic [SCALE_W-1:0]    speed_scale;
  } cfg_t;

endpackage

/* hdl/ssc_if.sv */
// ----------------------------------------------------------------------------
// Step cadence speed channels
// Sample and result channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface ssc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ssc_pkg::SAMPLE_W-1:0] accel_x;
  logic signed [ssc_pkg::SAMPLE_W-1:0] accel_y;
  logic signed [ssc_pkg::SAMPLE_W-1:0] accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface ssc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         step_seen;
  logic [ssc_pkg::SPEED_W-1:0]  speed_q8;
  logic                         idle;
  modport source (output valid, step_seen, speed_q8, idle, input ready);
  modport sink (input valid, step_seen, speed_q8, idle, output ready);
endinterface

/* hdl/ssc_front.sv */
// ----------------------------------------------------------------------------
// Step cadence front end
// Deadband hold, window thresholds, dominant axis and step candidate detection.
// ----------------------------------------------------------------------------
module ssc_front #(
  parameter int THRESH_WINDOW = ssc_pkg::DEF_THRESH_WINDOW
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic signed [ssc_pkg::SAMPLE_W-1:0] accel [3],
  input  logic [ssc_pkg::DEADBAND_W-1:0]      deadband,
  output logic                                step_cand
);

  logic signed [ssc_pkg::SAMPLE_W-1:0] held_r [3];
  logic signed [ssc_pkg::SAMPLE_W-1:0] held_nxt [3];
  logic signed [ssc_pkg::SAMPLE_W-1:0] wmax_r [3];
  logic signed [ssc_pkg::SAMPLE_W-1:0] wmax_nxt [3];
  logic signed [ssc_pkg::SAMPLE_W-1:0] wmin_r [3];
  logic signed [ssc_pkg::SAMPLE_W-1:0] wmin_nxt [3];
  logic signed [ssc_pkg::THRESH_W-1:0] thr_r [3];
  logic signed [ssc_pkg::THRESH_W-1:0] thr_nxt [3];
  logic [ssc_pkg::WCOUNT_W-1:0]        wcount_r;
  logic [ssc_pkg::WCOUNT_W-1:0]        wcount_nxt;
  logic [ssc_pkg::THRESH_W-1:0]        change [3];
  logic [ssc_pkg::WCOUNT_W-1:0]        wcount_inc;
  logic                                wrap;
  logic [1:0]                          axis;
  logic [ssc_pkg::THRESH_W-1:0]        best;

  function automatic logic [ssc_pkg::THRESH_W-1:0] mag_diff(
    input logic signed [ssc_pkg::SAMPLE_W-1:0] a,
    input logic signed [ssc_pkg::SAMPLE_W-1:0] b
  );
    logic signed [ssc_pkg::THRESH_W-1:0] d;
    d = ssc_pkg::THRESH_W'(a) - ssc_pkg::THRESH_W'(b);
    return d[ssc_pkg::THRESH_W-1] ? ssc_pkg::THRESH_W'(-d) : ssc_pkg::THRESH_W'(d);
  endfunction

  always_comb begin
    wcount_inc = wcount_r + 1'b1;
    wrap       = (wcount_inc >= ssc_pkg::WCOUNT_W'(THRESH_WINDOW));
    wcount_nxt = wrap ? '0 : wcount_inc;
    for (int i = 0; i < 3; i++) begin
      held_nxt[i] = (mag_diff(accel[i], held_r[i]) >
                     ssc_pkg::THRESH_W'(deadband)) ? accel[i] : held_r[i];
      wmax_nxt[i] = (accel[i] > wmax_r[i]) ? accel[i] : wmax_r[i];
      wmin_nxt[i] = (accel[i] < wmin_r[i]) ? accel[i] : wmin_r[i];
      thr_nxt[i]  = wrap ? (ssc_pkg::THRESH_W'(wmax_nxt[i]) + ssc_pkg::THRESH_W'(wmin_nxt[i]))
                         : thr_r[i];
      change[i]   = mag_diff(held_nxt[i], held_r[i]);
    end
    axis = 2'd0;
    best = change[0];
    for (int i = 1; i < 3; i++) begin
      if (change[i] > best) begin
        best = change[i];
        axis = 2'(i);
      end
    end
    step_cand = (held_nxt[axis] < held_r[axis]) &&
                ($signed({held_nxt[axis], 1'b0}) < thr_nxt[axis]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcount_r <= '0;
      for (int i = 0; i < 3; i++) begin
        held_r[i] <= '0;
        thr_r[i]  <= '0;
        wmax_r[i] <= {1'b1, {(ssc_pkg::SAMPLE_W-1){1'b0}}};
        wmin_r[i] <= {1'b0, {(ssc_pkg::SAMPLE_W-1){1'b1}}};
      end
    end else if (push) begin
      wcount_r <= wcount_nxt;
      for (int i = 0; i < 3; i++) begin
        held_r[i] <= held_nxt[i];
        thr_r[i]  <= thr_nxt[i];
        wmax_r[i] <= wrap ? {1'b1, {(ssc_pkg::SAMPLE_W-1){1'b0}}} : wmax_nxt[i];
        wmin_r[i] <= wrap ? {1'b0, {(ssc_pkg::SAMPLE_W-1){1'b1}}} : wmin_nxt[i];
      end
    end
  end

endmodule

/* hdl/ssc_queue.sv */
// ----------------------------------------------------------------------------
// Step cadence candidate queue
// Two-entry queue of step candidates between the front and back ends.
// ----------------------------------------------------------------------------
module ssc_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  logic push_data,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output logic pop_data
);

  logic [1:0] data_r;
  logic [1:0] data_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  always_comb begin
    data_nxt  = data_r;
    count_nxt = count_r;
    if (pop && count_r != 2'd0) begin
      data_nxt[0] = data_r[1];
      count_nxt   = count_nxt - 2'd1;
    end
    if (push && !full) begin
      data_nxt[count_nxt[0]] = push_data;
      count_nxt              = count_nxt + 2'd1;
    end
  end

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = data_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    data_r <= data_nxt;
  end

endmodule

/* hdl/ssc_back.sv */
// ----------------------------------------------------------------------------
// Step cadence back end
// Interval timing, interval ring, speed division and the result register.
// ----------------------------------------------------------------------------
module ssc_back #(
  parameter int RING_DEPTH = ssc_pkg::DEF_RING_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ssc_pkg::cfg_t               cfg,
  input  logic                        q_not_empty,
  input  logic                        q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_step,
  output logic [ssc_pkg::SPEED_W-1:0] out_speed,
  output logic                        out_idle
);

  localparam int POS_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = ssc_pkg::INTERVAL_W + $clog2(RING_DEPTH) + 1;
  localparam int NUM_W  = ssc_pkg::SCALE_W + FILL_W;
  localparam int CNT_W  = $clog2(NUM_W + 1);

  localparam logic [1:0] ST_WAIT = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  logic [1:0]                          state_r, state_nxt;
  logic                                idle_r, idle_nxt;
  logic [ssc_pkg::TICK_W-1:0]          tick_r, tick_nxt;
  logic                                cand_r, cand_nxt;
  logic [ssc_pkg::PRODUCT_W-1:0]       ival_r, ival_nxt;
  logic [ssc_pkg::INTERVAL_W-1:0]      ring_r [RING_DEPTH];
  logic [POS_W-1:0]                    pos_r, pos_nxt;
  logic [FILL_W-1:0]                   fill_r, fill_nxt;
  logic [SUM_W-1:0]                    sum_r, sum_nxt;
  logic [ssc_pkg::SPEED_W-1:0]         speed_r, speed_nxt;
  logic [NUM_W-1:0]                    num_r, num_nxt;
  logic [SUM_W:0]                      rem_r, rem_nxt;
  logic [CNT_W-1:0]                    cnt_r, cnt_nxt;
  logic                                ov_r, ov_nxt;
  logic                                ostep_r, ostep_nxt;
  logic [ssc_pkg::SPEED_W-1:0]         ospeed_r, ospeed_nxt;
  logic                                oidle_r, oidle_nxt;
  logic                                ring_we;
  logic [ssc_pkg::INTERVAL_W-1:0]      ival_sat;
  logic [ssc_pkg::INTERVAL_W-1:0]      old_entry;
  logic [SUM_W:0]                      rem_shift;

  always_comb begin
    state_nxt  = state_r;
    idle_nxt   = idle_r;
    tick_nxt   = tick_r;
    cand_nxt   = cand_r;
    ival_nxt   = ival_r;
    pos_nxt    = pos_r;
    fill_nxt   = fill_r;
    sum_nxt    = sum_r;
    speed_nxt  = speed_r;
    num_nxt    = num_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    ov_nxt     = ov_r && !out_ready;
    ostep_nxt  = ostep_r;
    ospeed_nxt = ospeed_r;
    oidle_nxt  = oidle_r;
    q_pop      = 1'b0;
    ring_we    = 1'b0;
    ival_sat   = (ival_r > ssc_pkg::PRODUCT_W'({ssc_pkg::INTERVAL_W{1'b1}})) ?
                 {ssc_pkg::INTERVAL_W{1'b1}} : ival_r[ssc_pkg::INTERVAL_W-1:0];
    old_entry  = (fill_r == FILL_W'(RING_DEPTH)) ? ring_r[pos_r] : '0;
    rem_shift  = {rem_r[SUM_W-1:0], num_r[NUM_W-1]};
    unique case (state_r)
      ST_WAIT: begin
        if (q_not_empty && !ov_r) begin
          q_pop     = 1'b1;
          cand_nxt  = q_data;
          idle_nxt  = idle_r && !q_data;
          if (!(idle_r && !q_data) && tick_r != {ssc_pkg::TICK_W{1'b1}}) begin
            tick_nxt = tick_r + 1'b1;
          end
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        ival_nxt  = ssc_pkg::PRODUCT_W'(tick_r) * ssc_pkg::PRODUCT_W'(cfg.sample_period_ms);
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = ST_WAIT;
        if (ival_r > ssc_pkg::PRODUCT_W'(cfg.max_interval_ms)) begin
          idle_nxt   = 1'b1;
          tick_nxt   = '0;
          speed_nxt  = '0;
          pos_nxt    = '0;
          fill_nxt   = '0;
          sum_nxt    = '0;
          ov_nxt     = 1'b1;
          ostep_nxt  = 1'b0;
          ospeed_nxt = '0;
          oidle_nxt  = 1'b1;
        end else if (cand_r && ival_r >= ssc_pkg::PRODUCT_W'(cfg.min_interval_ms)) begin
          ring_we   = 1'b1;
          sum_nxt   = sum_r - SUM_W'(old_entry) + SUM_W'(ival_sat);
          pos_nxt   = (pos_r == POS_W'(RING_DEPTH - 1)) ? '0 : pos_r + 1'b1;
          if (fill_r != FILL_W'(RING_DEPTH)) begin
            fill_nxt = fill_r + 1'b1;
          end
          tick_nxt  = '0;
          if (fill_nxt <= FILL_W'(3)) begin
            speed_nxt  = '0;
            ov_nxt     = 1'b1;
            ostep_nxt  = 1'b1;
            ospeed_nxt = '0;
            oidle_nxt  = idle_r;
          end else if (sum_nxt == '0) begin
            speed_nxt  = ssc_pkg::SPEED_MAX_Q8;
            ov_nxt     = 1'b1;
            ostep_nxt  = 1'b1;
            ospeed_nxt = ssc_pkg::SPEED_MAX_Q8;
            oidle_nxt  = idle_r;
          end else begin
            num_nxt   = NUM_W'(cfg.speed_scale) * NUM_W'(fill_nxt);
            rem_nxt   = '0;
            cnt_nxt   = CNT_W'(NUM_W);
            state_nxt = ST_DIV;
          end
        end else begin
          ov_nxt     = 1'b1;
          ostep_nxt  = 1'b0;
          ospeed_nxt = speed_r;
          oidle_nxt  = idle_r;
        end
      end
      ST_DIV: begin
        if (rem_shift >= {1'b0, sum_r}) begin
          rem_nxt = rem_shift - {1'b0, sum_r};
          num_nxt = {num_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_shift;
          num_nxt = {num_r[NUM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          speed_nxt  = (num_nxt > NUM_W'(ssc_pkg::SPEED_MAX_Q8)) ?
                       ssc_pkg::SPEED_MAX_Q8 : num_nxt[ssc_pkg::SPEED_W-1:0];
          ov_nxt     = 1'b1;
          ostep_nxt  = 1'b1;
          ospeed_nxt = speed_nxt;
          oidle_nxt  = idle_r;
          state_nxt  = ST_WAIT;
        end
      end
      default: state_nxt = ST_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WAIT;
      idle_r  <= 1'b1;
      tick_r  <= '0;
      pos_r   <= '0;
      fill_r  <= '0;
      sum_r   <= '0;
      speed_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idle_r  <= idle_nxt;
      tick_r  <= tick_nxt;
      pos_r   <= pos_nxt;
      fill_r  <= fill_nxt;
      sum_r   <= sum_nxt;
      speed_r <= speed_nxt;
      ov_r    <= ov_nxt;
    end
    cand_r   <= cand_nxt;
    ival_r   <= ival_nxt;
    num_r    <= num_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    ostep_r  <= ostep_nxt;
    ospeed_r <= ospeed_nxt;
    oidle_r  <= oidle_nxt;
    if (ring_we) begin
      ring_r[pos_r] <= ival_sat;
    end
  end

  assign out_valid = ov_r;
  assign out_step  = ostep_r;
  assign out_speed = ospeed_r;
  assign out_idle  = oidle_r;

endmodule

/* hdl/accel_step_cadence_speed.sv */
// ----------------------------------------------------------------------------
// Step cadence speed detector
// Detects steps in accelerometer samples and derives a cadence based speed.
// ----------------------------------------------------------------------------
// Each sample item yields one result item. The front end takes a sample while
// the queue is not full and queues a step candidate. The back end takes one
// candidate at a time through the wait, multiply, evaluate and, for a new
// speed, divide states, one quotient bit per cycle. The user keeps registers
// written over the APB port only while the block is idle (not enforced).
module accel_step_cadence_speed #(
  parameter int THRESH_WINDOW = ssc_pkg::DEF_THRESH_WINDOW,
  parameter int RING_DEPTH    = ssc_pkg::DEF_RING_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ssc_in_if.sink                      in_ch,
  ssc_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ssc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [ssc_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [ssc_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  ssc_pkg::cfg_t                       cfg_r;
  logic                                q_full;
  logic                                q_not_empty;
  logic                                q_data;
  logic                                q_pop;
  logic                                push;
  logic                                step_cand;
  logic signed [ssc_pkg::SAMPLE_W-1:0] accel [3];
  logic [2:0]                          reg_idx;
  logic                                wr_en;

  assign accel[0]     = in_ch.accel_x;
  assign accel[1]     = in_ch.accel_y;
  assign accel[2]     = in_ch.accel_z;
  assign in_ch.ready  = !q_full;
  assign push         = in_ch.valid && !q_full;
  assign cfg_pready   = 1'b1;
  assign reg_idx      = cfg_paddr[4:2];
  assign wr_en        = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (reg_idx)
      ssc_pkg::REG_DEADBAND: cfg_prdata = ssc_pkg::DATA_W'(cfg_r.deadband);
      ssc_pkg::REG_PERIOD:   cfg_prdata = ssc_pkg::DATA_W'(cfg_r.sample_period_ms);
      ssc_pkg::REG_MIN_IVAL: cfg_prdata = ssc_pkg::DATA_W'(cfg_r.min_interval_ms);
      ssc_pkg::REG_MAX_IVAL: cfg_prdata = ssc_pkg::DATA_W'(cfg_r.max_interval_ms);
      ssc_pkg::REG_SCALE:    cfg_prdata = ssc_pkg::DATA_W'(cfg_r.speed_scale);
      default:               cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband         <= ssc_pkg::RST_DEADBAND;
      cfg_r.sample_period_ms <= ssc_pkg::RST_PERIOD;
      cfg_r.min_interval_ms  <= ssc_pkg::RST_MIN_IVAL;
      cfg_r.max_interval_ms  <= ssc_pkg::RST_MAX_IVAL;
      cfg_r.speed_scale      <= ssc_pkg::RST_SCALE;
    end else if (wr_en && cfg_paddr[1:0] == 2'b00) begin
      unique case (reg_idx)
        ssc_pkg::REG_DEADBAND: cfg_r.deadband <= cfg_pwdata[ssc_pkg::DEADBAND_W-1:0];
        ssc_pkg::REG_PERIOD:   cfg_r.sample_period_ms <= cfg_pwdata[ssc_pkg::PERIOD_W-1:0];
        ssc_pkg::REG_MIN_IVAL: cfg_r.min_interval_ms <= cfg_pwdata[15:0];
        ssc_pkg::REG_MAX_IVAL: cfg_r.max_interval_ms <= cfg_pwdata[15:0];
        ssc_pkg::REG_SCALE:    cfg_r.speed_scale <= cfg_pwdata[ssc_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  ssc_front #(.THRESH_WINDOW(THRESH_WINDOW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .accel     (accel),
    .deadband  (cfg_r.deadband),
    .step_cand (step_cand)
  );

  ssc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (step_cand),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  ssc_back #(.RING_DEPTH(RING_DEPTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_step    (out_ch.step_seen),
    .out_speed   (out_ch.speed_q8),
    .out_idle    (out_ch.idle)
  );

endmodule

/* hdl/ssc_checker.sv */
// ----------------------------------------------------------------------------
// Step cadence checker
// Port level properties of the step cadence speed detector.
// ----------------------------------------------------------------------------
module ssc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_step,
  input logic [ssc_pkg::SPEED_W-1:0] out_speed,
  input logic                        out_idle
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result item dropped before it was taken.");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_idle |-> !out_step && out_speed == '0)
    else $error("Idle result carries a step or a speed.");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_speed <= ssc_pkg::SPEED_MAX_Q8)
    else $error("Speed exceeds its clamp.");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid straight after reset.");

endmodule

bind accel_step_cadence_speed ssc_checker u_ssc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_step  (out_ch.step_seen),
  .out_speed (out_ch.speed_q8),
  .out_idle  (out_ch.idle)
);
